@@ rtl/core/sst_pkg.sv @@
// Shared types, codes and sizes of the scoped symbol table.
package sst_pkg;

   localparam int TABLE_ENTRIES = 128;
   localparam int NAME_WORDS    = 4;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

   localparam logic [63:0] NAME_MASK = 64'((65'd1 << (16 * NAME_WORDS)) - 65'd1);

   localparam logic [2:0] OP_INSERT     = 3'd0;
   localparam logic [2:0] OP_FIND       = 3'd1;
   localparam logic [2:0] OP_READ       = 3'd2;
   localparam logic [2:0] OP_WR_ADDRESS = 3'd3;
   localparam logic [2:0] OP_WR_VALUE   = 3'd4;
   localparam logic [2:0] OP_WR_CLASS   = 3'd5;
   localparam logic [2:0] OP_WR_DEFINED = 3'd6;
   localparam logic [2:0] OP_POP_LOCALS = 3'd7;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_DUP      = 3'd1;
   localparam logic [2:0] ST_FULL     = 3'd2;
   localparam logic [2:0] ST_NOTFOUND = 3'd3;
   localparam logic [2:0] ST_RANGE    = 3'd4;

   localparam int          FLAG_DEFINED = 15;
   localparam int          FLAG_LOCAL   = 14;
   localparam logic [15:0] CLASS_KEEP   = 16'hfffc;

   typedef struct packed {
      logic [63:0] name;
      logic [15:0] address;
      logic [15:0] value;
      logic [15:0] flags;
   } entry_type;

   typedef struct packed {
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      entry_type        wr_data;
   } mem_req_type;

   typedef struct packed {
      logic [2:0]       status;
      logic [IDX_W-1:0] index;
      logic [15:0]      address;
      logic [15:0]      value;
      logic [1:0]       cls;
      logic             def_bit;
      logic             is_local;
      logic [CNT_W-1:0] removed;
   } rsp_type;

   function automatic rsp_type entry_rsp(logic [2:0] status, logic [IDX_W-1:0] idx,
                                         entry_type e);
      rsp_type r;
      r          = '0;
      r.status   = status;
      r.index    = idx;
      r.address  = e.address;
      r.value    = e.value;
      r.cls      = e.flags[1:0];
      r.def_bit  = e.flags[FLAG_DEFINED];
      r.is_local = e.flags[FLAG_LOCAL];
      return r;
   endfunction

endpackage

@@ rtl/core/scoped_symbol_table.sv @@
// Scoped symbol table: a stack of up to 128 entries (name, address, value, flags)
// held in one single-port-read, single-port-write memory with a registered read.
// Items are handled one at a time. Find and insert walk the table from the
// newest entry down, one entry per cycle, until a name match or the bottom;
// remove locals walks down the same way while the entries are local. Read and
// the writes read the addressed entry, and the writes write it back modified.
// A finished result sits in an output register, so the next item is taken
// while the previous result still waits on rsp_ready. No clearing pass is
// needed after reset: only entries below the entry count are ever read.
module scoped_symbol_table (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [2:0]                req_operation,
   input  logic [63:0]               req_name_key,
   input  logic                      req_is_local,
   input  logic [sst_pkg::IDX_W-1:0] req_entry_index,
   input  logic [15:0]               req_address_in,
   input  logic [15:0]               req_value_in,
   input  logic [15:0]               req_flags_in,
   input  logic [1:0]                req_class_in,
   input  logic                      req_defined_in,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [2:0]                rsp_status,
   output logic [sst_pkg::IDX_W-1:0] rsp_index_out,
   output logic [15:0]               rsp_address_out,
   output logic [15:0]               rsp_value_out,
   output logic [1:0]                rsp_class_out,
   output logic                      rsp_defined_out,
   output logic                      rsp_local_out,
   output logic [sst_pkg::CNT_W-1:0] rsp_removed_count
);
   import sst_pkg::*;

   mem_req_type mem_req;
   entry_type   mem_rd_data;
   rsp_type     res;
   logic        res_valid;
   logic        res_take;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff;

   sst_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (mem_rd_data)
   );

   sst_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_name_key    (req_name_key),
      .req_is_local    (req_is_local),
      .req_entry_index (req_entry_index),
      .req_address_in  (req_address_in),
      .req_value_in    (req_value_in),
      .req_flags_in    (req_flags_in),
      .req_class_in    (req_class_in),
      .req_defined_in  (req_defined_in),
      .mem_req         (mem_req),
      .mem_rd_data     (mem_rd_data),
      .res             (res),
      .res_valid       (res_valid),
      .res_take        (res_take)
   );

   // load the output register when it is empty or being drained
   assign res_take = res_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_ff.status;
   assign rsp_index_out     = rsp_ff.index;
   assign rsp_address_out   = rsp_ff.address;
   assign rsp_value_out     = rsp_ff.value;
   assign rsp_class_out     = rsp_ff.cls;
   assign rsp_defined_out   = rsp_ff.def_bit;
   assign rsp_local_out     = rsp_ff.is_local;
   assign rsp_removed_count = rsp_ff.removed;

endmodule

@@ rtl/core/sst_store.sv @@
// Entry memory: one write port and one registered read port.
module sst_store (
   input  logic                clock,
   input  sst_pkg::mem_req_type mem_req,
   output sst_pkg::entry_type   rd_data
);
   import sst_pkg::*;

   entry_type entry_mem [TABLE_ENTRIES];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         entry_mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= entry_mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/sst_seq.sv @@
// Sequencer: takes one item, walks or modifies the entry memory, builds the result.
module sst_seq (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [2:0]                   req_operation,
   input  logic [63:0]                  req_name_key,
   input  logic                         req_is_local,
   input  logic [sst_pkg::IDX_W-1:0]    req_entry_index,
   input  logic [15:0]                  req_address_in,
   input  logic [15:0]                  req_value_in,
   input  logic [15:0]                  req_flags_in,
   input  logic [1:0]                   req_class_in,
   input  logic                         req_defined_in,
   output sst_pkg::mem_req_type         mem_req,
   input  sst_pkg::entry_type           mem_rd_data,
   output sst_pkg::rsp_type             res,
   output logic                         res_valid,
   input  logic                         res_take
);
   import sst_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_RMW  = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic             pend_ff, pend_in;
   logic [IDX_W-1:0] pend_idx_ff, pend_idx_in;
   logic [CNT_W-1:0] removed_ff, removed_in;
   rsp_type          res_ff, res_in;

   logic [2:0]       op_ff;
   logic [63:0]      key_ff;
   logic             loc_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [15:0]      addr_ff;
   logic [15:0]      val_ff;
   logic [15:0]      flg_ff;
   logic [1:0]       cls_ff;
   logic             def_ff;

   logic             hit;
   logic             rd_local;
   logic             stop;
   logic             walk_end;
   logic             append;
   entry_type        new_entry;
   entry_type        ins_entry;

   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res       = res_ff;

   assign hit      = ((mem_rd_data.name ^ key_ff) & NAME_MASK) == 64'd0;
   assign rd_local = mem_rd_data.flags[FLAG_LOCAL];
   assign ins_entry = '{name: key_ff, address: addr_ff, value: val_ff, flags: flg_ff};

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      ptr_in      = ptr_ff;
      pend_in     = pend_ff;
      pend_idx_in = pend_idx_ff;
      removed_in  = removed_ff;
      res_in      = res_ff;
      mem_req     = '0;
      stop        = 1'b0;
      walk_end    = 1'b0;
      append      = 1'b0;
      new_entry   = mem_rd_data;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_operation) inside
                  OP_INSERT, OP_FIND, OP_POP_LOCALS: begin
                     state_in   = S_SCAN;
                     ptr_in     = count_ff;
                     pend_in    = 1'b0;
                     removed_in = '0;
                  end
                  default: begin
                     if (CNT_W'(req_entry_index) >= count_ff) begin
                        res_in        = '0;
                        res_in.status = ST_RANGE;
                        res_in.index  = req_entry_index;
                        state_in      = S_DONE;
                     end else begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = req_entry_index;
                        state_in        = S_RMW;
                     end
                  end
               endcase
            end
         end

         S_SCAN: begin
            pend_in = 1'b0;
            // judge the entry read last cycle
            if (pend_ff) begin
               if (op_ff == OP_POP_LOCALS) begin
                  if (rd_local) begin
                     count_in   = CNT_W'(pend_idx_ff);
                     removed_in = removed_ff + CNT_W'(1);
                  end else begin
                     stop = 1'b1;
                  end
               end else if (hit) begin
                  stop = 1'b1;
               end
            end

            // read ahead one entry, newest first
            if (!stop) begin
               if (ptr_ff != '0) begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = IDX_W'(ptr_ff - CNT_W'(1));
                  ptr_in          = ptr_ff - CNT_W'(1);
                  pend_in         = 1'b1;
                  pend_idx_in     = IDX_W'(ptr_ff - CNT_W'(1));
               end else if (!pend_ff) begin
                  walk_end = 1'b1;
               end
            end

            if (stop || walk_end) begin
               state_in = S_DONE;
               case (op_ff)
                  OP_POP_LOCALS: begin
                     res_in         = '0;
                     res_in.status  = ST_OK;
                     res_in.removed = removed_ff;
                  end
                  OP_FIND: begin
                     if (stop) begin
                        res_in = entry_rsp(ST_OK, pend_idx_ff, mem_rd_data);
                     end else begin
                        res_in        = '0;
                        res_in.status = ST_NOTFOUND;
                     end
                  end
                  default: begin
                     if (stop && (rd_local == loc_ff)) begin
                        res_in = entry_rsp(ST_DUP, pend_idx_ff, mem_rd_data);
                     end else begin
                        append = 1'b1;
                     end
                  end
               endcase
            end

            if (append) begin
               if (count_ff >= CNT_W'(TABLE_ENTRIES)) begin
                  res_in        = '0;
                  res_in.status = ST_FULL;
               end else begin
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_addr = IDX_W'(count_ff);
                  mem_req.wr_data = ins_entry;
                  count_in        = count_ff + CNT_W'(1);
                  res_in          = entry_rsp(ST_OK, IDX_W'(count_ff), ins_entry);
               end
            end
         end

         S_RMW: begin
            case (op_ff)
               OP_WR_ADDRESS: new_entry.address = addr_ff;
               OP_WR_VALUE:   new_entry.value = val_ff;
               OP_WR_CLASS:   new_entry.flags = (mem_rd_data.flags & CLASS_KEEP) | {14'd0, cls_ff};
               OP_WR_DEFINED: new_entry.flags[FLAG_DEFINED] = def_ff;
               default:       new_entry = mem_rd_data;
            endcase
            mem_req.wr_en   = (op_ff != OP_READ);
            mem_req.wr_addr = idx_ff;
            mem_req.wr_data = new_entry;
            res_in          = entry_rsp(ST_OK, idx_ff, new_entry);
            state_in        = S_DONE;
         end

         default: begin
            // hold the result until the output register takes it
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         pend_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         pend_ff    <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff      <= ptr_in;
      pend_idx_ff <= pend_idx_in;
      removed_ff  <= removed_in;
      res_ff      <= res_in;
      if (req_valid && req_ready) begin
         op_ff   <= req_operation;
         key_ff  <= req_name_key;
         loc_ff  <= req_is_local;
         idx_ff  <= req_entry_index;
         addr_ff <= req_address_in;
         val_ff  <= req_value_in;
         flg_ff  <= req_flags_in;
         cls_ff  <= req_class_in;
         def_ff  <= req_defined_in;
      end
   end

endmodule
